/* hw/rtl/ps2_keyboard_mouse_byte_decoder_unit_defines.svh */
// ----------------------------------------------------------------------------
// PS/2 byte decoder assertion macros
// Shared concurrent assertion forms for the decoder checkers.
// ----------------------------------------------------------------------------
`ifndef PS2_KEYBOARD_MOUSE_BYTE_DECODER_UNIT_DEFINES_SVH
`define PS2_KEYBOARD_MOUSE_BYTE_DECODER_UNIT_DEFINES_SVH

// checked outside reset only
`define PS2KB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define PS2KB_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/ps2kb_pkg.sv */
// ----------------------------------------------------------------------------
// PS/2 byte decoder package
// Widths, register indexes, event codes and the set-1 scancode map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ps2kb_pkg;

   localparam int COORD_BITS_DEFAULT = 12;
   localparam int DATA_BITS          = 8;
   localparam int CHAR_BITS          = 7;
   localparam int CSR_ADDR_BITS      = 3;
   localparam int CSR_DATA_BITS      = 32;
   localparam int MAX_RESET          = 99;
   localparam int BREAK_BIT          = 7;
   localparam int LEFT_BIT           = 0;
   localparam int RIGHT_BIT          = 1;

   localparam logic [1:0] PKT_FIRST_INDEX = 2'd0;
   localparam logic [1:0] PKT_DX_INDEX    = 2'd1;
   localparam logic [1:0] PKT_LAST_INDEX  = 2'd2;

   typedef enum logic {
      CSR_MAX_X = 1'b0,
      CSR_MAX_Y = 1'b1
   } csr_index_type;

   typedef enum logic {
      EVENT_POINTER = 1'b0,
      EVENT_KEY     = 1'b1
   } event_kind_type;

   function automatic logic [CHAR_BITS-1:0] scan_to_ascii(input logic [DATA_BITS-1:0] code);
      logic [CHAR_BITS-1:0] ch;
      case (code)
         8'h01: ch = 7'h1B;
         8'h02: ch = 7'h31;
         8'h03: ch = 7'h32;
         8'h04: ch = 7'h33;
         8'h05: ch = 7'h34;
         8'h06: ch = 7'h35;
         8'h07: ch = 7'h36;
         8'h08: ch = 7'h37;
         8'h09: ch = 7'h38;
         8'h0A: ch = 7'h39;
         8'h0B: ch = 7'h30;
         8'h0C: ch = 7'h2D;
         8'h0D: ch = 7'h3D;
         8'h0E: ch = 7'h08;
         8'h0F: ch = 7'h09;
         8'h10: ch = 7'h71;
         8'h11: ch = 7'h77;
         8'h12: ch = 7'h65;
         8'h13: ch = 7'h72;
         8'h14: ch = 7'h74;
         8'h15: ch = 7'h79;
         8'h16: ch = 7'h75;
         8'h17: ch = 7'h69;
         8'h18: ch = 7'h6F;
         8'h19: ch = 7'h70;
         8'h1A: ch = 7'h5B;
         8'h1B: ch = 7'h5D;
         8'h1C: ch = 7'h0A;
         8'h1E: ch = 7'h61;
         8'h1F: ch = 7'h73;
         8'h20: ch = 7'h64;
         8'h21: ch = 7'h66;
         8'h22: ch = 7'h67;
         8'h23: ch = 7'h68;
         8'h24: ch = 7'h6A;
         8'h25: ch = 7'h6B;
         8'h26: ch = 7'h6C;
         8'h27: ch = 7'h3B;
         8'h28: ch = 7'h27;
         8'h29: ch = 7'h60;
         8'h2B: ch = 7'h5C;
         8'h2C: ch = 7'h7A;
         8'h2D: ch = 7'h78;
         8'h2E: ch = 7'h63;
         8'h2F: ch = 7'h76;
         8'h30: ch = 7'h62;
         8'h31: ch = 7'h6E;
         8'h32: ch = 7'h6D;
         8'h33: ch = 7'h2C;
         8'h34: ch = 7'h2E;
         8'h35: ch = 7'h2F;
         8'h37: ch = 7'h2A;
         8'h39: ch = 7'h20;
         default: ch = '0;
      endcase
      return ch;
   endfunction

endpackage

/* hw/rtl/ps2kb_req_if.sv */
// ----------------------------------------------------------------------------
// PS/2 byte decoder request channel
// Valid/ready channel carrying one controller byte and its source port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ps2kb_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [ps2kb_pkg::DATA_BITS-1:0]      data_byte;
   logic                                 from_mouse;

   modport source (output valid, output data_byte, output from_mouse, input ready);
   modport sink   (input valid, input data_byte, input from_mouse, output ready);
endinterface

/* hw/rtl/ps2kb_rsp_if.sv */
// ----------------------------------------------------------------------------
// PS/2 byte decoder result channel
// Valid/ready channel carrying one pointer or key character event.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ps2kb_rsp_if #(
   parameter int COORD_BITS = ps2kb_pkg::COORD_BITS_DEFAULT
);
   logic                                 valid;
   logic                                 ready;
   logic                                 event_kind;
   logic [COORD_BITS-1:0]                pointer_x;
   logic [COORD_BITS-1:0]                pointer_y;
   logic                                 left_button;
   logic                                 right_button;
   logic [ps2kb_pkg::CHAR_BITS-1:0]      key_char;

   modport source (output valid, output event_kind, output pointer_x, output pointer_y,
                   output left_button, output right_button, output key_char, input ready);
   modport sink   (input valid, input event_kind, input pointer_x, input pointer_y,
                   input left_button, input right_button, input key_char, output ready);
endinterface

/* hw/rtl/ps2_keyboard_mouse_byte_decoder_unit.sv */
// A request passes from the input register through decode into the result register; rsp stall holds it.
// Throughput: one request per cycle while rsp is not stalled; a request that makes no event
// still takes one pass through the input register and the decode stage.
// Reset: synchronous, active high; clears both stage valids, packet index, pointer,
// last reported position, last scancode; bounds return to 99. No clearing pass.
// ----------------------------------------------------------------------------
// PS/2 keyboard and mouse byte decoder
// Input register, single-pass decode of mouse packets and scancodes, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ps2_keyboard_mouse_byte_decoder_unit #(
   parameter int COORD_BITS = ps2kb_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   ps2kb_req_if.sink                             req,
   ps2kb_rsp_if.source                           rsp,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [ps2kb_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [ps2kb_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [ps2kb_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                  pready
);

   logic                                 in_valid_ff;
   logic [ps2kb_pkg::DATA_BITS-1:0]      in_data_ff;
   logic                                 in_mouse_ff;
   logic                                 advance;

   logic                                 out_valid_ff;
   logic                                 out_valid_in;
   ps2kb_pkg::event_kind_type            out_kind_ff;
   logic [COORD_BITS-1:0]                out_x_ff;
   logic [COORD_BITS-1:0]                out_y_ff;
   logic                                 out_left_ff;
   logic                                 out_right_ff;
   logic [ps2kb_pkg::CHAR_BITS-1:0]      out_char_ff;

   logic [COORD_BITS-1:0]                max_x;
   logic [COORD_BITS-1:0]                max_y;
   logic                                 set_x;
   logic                                 set_y;
   logic [COORD_BITS-1:0]                center;

   logic                                 m_hit;
   logic [COORD_BITS-1:0]                m_x;
   logic [COORD_BITS-1:0]                m_y;
   logic                                 m_left;
   logic                                 m_right;
   logic                                 k_hit;
   logic [ps2kb_pkg::CHAR_BITS-1:0]      k_char;
   logic                                 hit;

   assign advance      = in_valid_ff & (~out_valid_ff | rsp.ready);
   assign req.ready    = ~in_valid_ff | advance;
   assign hit          = in_mouse_ff ? m_hit : k_hit;
   assign out_valid_in = advance ? hit : (out_valid_ff & ~rsp.ready);

   ps2kb_csr #(.COORD_BITS(COORD_BITS)) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .max_x   (max_x),
      .max_y   (max_y),
      .set_x   (set_x),
      .set_y   (set_y),
      .center  (center)
   );

   ps2kb_mouse #(.COORD_BITS(COORD_BITS)) u_mouse (
      .clock        (clock),
      .reset        (reset),
      .step         (advance & in_mouse_ff),
      .data         (in_data_ff),
      .max_x        (max_x),
      .max_y        (max_y),
      .set_x        (set_x),
      .set_y        (set_y),
      .center       (center),
      .hit          (m_hit),
      .pointer_x    (m_x),
      .pointer_y    (m_y),
      .left_button  (m_left),
      .right_button (m_right)
   );

   ps2kb_keys u_keys (
      .clock    (clock),
      .reset    (reset),
      .step     (advance & ~in_mouse_ff),
      .data     (in_data_ff),
      .hit      (k_hit),
      .key_char (k_char)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_data_ff  <= req.data_byte;
         in_mouse_ff <= req.from_mouse;
      end
      if (advance && hit) begin
         if (in_mouse_ff) begin
            out_kind_ff  <= ps2kb_pkg::EVENT_POINTER;
            out_x_ff     <= m_x;
            out_y_ff     <= m_y;
            out_left_ff  <= m_left;
            out_right_ff <= m_right;
            out_char_ff  <= '0;
         end else begin
            out_kind_ff  <= ps2kb_pkg::EVENT_KEY;
            out_x_ff     <= '0;
            out_y_ff     <= '0;
            out_left_ff  <= 1'b0;
            out_right_ff <= 1'b0;
            out_char_ff  <= k_char;
         end
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.event_kind   = out_kind_ff;
   assign rsp.pointer_x    = out_x_ff;
   assign rsp.pointer_y    = out_y_ff;
   assign rsp.left_button  = out_left_ff;
   assign rsp.right_button = out_right_ff;
   assign rsp.key_char     = out_char_ff;

endmodule

/* hw/rtl/ps2kb_csr.sv */
// ----------------------------------------------------------------------------
// PS/2 byte decoder register file
// APB-style access to the pointer bounds; a write also requests re-centering.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ps2kb_csr #(
   parameter int COORD_BITS = ps2kb_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [ps2kb_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [ps2kb_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [ps2kb_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                  pready,
   output logic [COORD_BITS-1:0]                 max_x,
   output logic [COORD_BITS-1:0]                 max_y,
   output logic                                  set_x,
   output logic                                  set_y,
   output logic [COORD_BITS-1:0]                 center
);

   logic [COORD_BITS-1:0]      max_x_ff;
   logic [COORD_BITS-1:0]      max_y_ff;
   logic [COORD_BITS-1:0]      wdata;
   logic [COORD_BITS:0]        wdata_inc;
   logic                       wr_en;
   ps2kb_pkg::csr_index_type   index;

   assign pready    = 1'b1;
   assign wr_en     = psel & penable & pwrite;
   assign index     = ps2kb_pkg::csr_index_type'(paddr[2]);
   assign wdata     = pwdata[COORD_BITS-1:0];
   assign wdata_inc = {1'b0, wdata} + {{COORD_BITS{1'b0}}, 1'b1};
   assign center    = wdata_inc[COORD_BITS:1];
   assign set_x     = wr_en & (index == ps2kb_pkg::CSR_MAX_X);
   assign set_y     = wr_en & (index == ps2kb_pkg::CSR_MAX_Y);
   assign max_x     = max_x_ff;
   assign max_y     = max_y_ff;

   always_comb begin
      prdata = '0;
      case (index)
         ps2kb_pkg::CSR_MAX_X: prdata[COORD_BITS-1:0] = max_x_ff;
         ps2kb_pkg::CSR_MAX_Y: prdata[COORD_BITS-1:0] = max_y_ff;
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_x_ff <= COORD_BITS'(ps2kb_pkg::MAX_RESET);
         max_y_ff <= COORD_BITS'(ps2kb_pkg::MAX_RESET);
      end else begin
         if (set_x) begin
            max_x_ff <= wdata;
         end
         if (set_y) begin
            max_y_ff <= wdata;
         end
      end
   end

endmodule

/* hw/rtl/ps2kb_mouse.sv */
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker
// Gathers three-byte packets, moves and clamps the pointer, flags a new report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ps2kb_mouse #(
   parameter int COORD_BITS = ps2kb_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic [ps2kb_pkg::DATA_BITS-1:0]     data,
   input  logic [COORD_BITS-1:0]               max_x,
   input  logic [COORD_BITS-1:0]               max_y,
   input  logic                                set_x,
   input  logic                                set_y,
   input  logic [COORD_BITS-1:0]               center,
   output logic                                hit,
   output logic [COORD_BITS-1:0]               pointer_x,
   output logic [COORD_BITS-1:0]               pointer_y,
   output logic                                left_button,
   output logic                                right_button
);

   localparam int SUM_BITS = COORD_BITS + 2;
   localparam int EXT_BITS = SUM_BITS - ps2kb_pkg::DATA_BITS;

   logic [1:0]                            index_ff;
   logic [1:0]                            index_in;
   logic [ps2kb_pkg::DATA_BITS-1:0]       byte0_ff;
   logic [ps2kb_pkg::DATA_BITS-1:0]       byte1_ff;
   logic [COORD_BITS-1:0]                 pos_x_ff;
   logic [COORD_BITS-1:0]                 pos_y_ff;
   logic [COORD_BITS-1:0]                 rep_x_ff;
   logic [COORD_BITS-1:0]                 rep_y_ff;
   logic [COORD_BITS-1:0]                 pos_x_in;
   logic [COORD_BITS-1:0]                 pos_y_in;
   logic signed [SUM_BITS-1:0]            sum_x;
   logic signed [SUM_BITS-1:0]            sum_y;
   logic                                  last;
   logic                                  moved;

   assign last = (index_ff == ps2kb_pkg::PKT_LAST_INDEX);

   always_comb begin
      sum_x = $signed({2'b00, pos_x_ff}) + $signed({{EXT_BITS{byte1_ff[7]}}, byte1_ff});
      sum_y = $signed({2'b00, pos_y_ff}) - $signed({{EXT_BITS{data[7]}}, data});
      if (sum_x[SUM_BITS-1]) begin
         pos_x_in = '0;
      end else if (sum_x > $signed({2'b00, max_x})) begin
         pos_x_in = max_x;
      end else begin
         pos_x_in = sum_x[COORD_BITS-1:0];
      end
      if (sum_y[SUM_BITS-1]) begin
         pos_y_in = '0;
      end else if (sum_y > $signed({2'b00, max_y})) begin
         pos_y_in = max_y;
      end else begin
         pos_y_in = sum_y[COORD_BITS-1:0];
      end
      moved    = (pos_x_in != rep_x_ff) | (pos_y_in != rep_y_ff);
      index_in = last ? ps2kb_pkg::PKT_FIRST_INDEX : index_ff + 2'd1;
   end

   assign hit          = last & moved;
   assign pointer_x    = pos_x_in;
   assign pointer_y    = pos_y_in;
   assign left_button  = byte0_ff[ps2kb_pkg::LEFT_BIT];
   assign right_button = byte0_ff[ps2kb_pkg::RIGHT_BIT];

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= ps2kb_pkg::PKT_FIRST_INDEX;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         rep_x_ff <= '0;
         rep_y_ff <= '0;
      end else begin
         if (step) begin
            index_ff <= index_in;
         end
         if (step && last && moved) begin
            rep_x_ff <= pos_x_in;
            rep_y_ff <= pos_y_in;
         end
         if (set_x) begin
            pos_x_ff <= center;
         end else if (step && last) begin
            pos_x_ff <= pos_x_in;
         end
         if (set_y) begin
            pos_y_ff <= center;
         end else if (step && last) begin
            pos_y_ff <= pos_y_in;
         end
      end
   end

   // packet bytes: no reset, always written before the third byte
   always_ff @(posedge clock) begin
      if (step && index_ff == ps2kb_pkg::PKT_FIRST_INDEX) begin
         byte0_ff <= data;
      end
      if (step && index_ff == ps2kb_pkg::PKT_DX_INDEX) begin
         byte1_ff <= data;
      end
   end

endmodule

/* hw/rtl/ps2kb_keys.sv */
// ----------------------------------------------------------------------------
// PS/2 set-1 scancode translator
// Drops break codes and repeats, maps make codes to ASCII characters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ps2kb_keys (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic [ps2kb_pkg::DATA_BITS-1:0]     data,
   output logic                                hit,
   output logic [ps2kb_pkg::CHAR_BITS-1:0]     key_char
);

   logic [ps2kb_pkg::DATA_BITS-1:0]   prev_ff;
   logic                              is_break;
   logic                              repeated;

   assign is_break = data[ps2kb_pkg::BREAK_BIT];
   assign repeated = (data == prev_ff);
   assign key_char = ps2kb_pkg::scan_to_ascii(data);
   assign hit      = ~is_break & ~repeated & (key_char != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else if (step) begin
         prev_ff <= data;
      end
   end

endmodule

/* hw/rtl/ps2kb_checker.sv */
// ----------------------------------------------------------------------------
// PS/2 byte decoder checker
// Port-level properties of the decoder, bound onto the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ps2_keyboard_mouse_byte_decoder_unit_defines.svh"

module ps2kb_checker #(
   parameter int COORD_BITS = ps2kb_pkg::COORD_BITS_DEFAULT
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_event_kind,
   input logic [COORD_BITS-1:0]               rsp_pointer_x,
   input logic [COORD_BITS-1:0]               rsp_pointer_y,
   input logic                                rsp_left_button,
   input logic                                rsp_right_button,
   input logic [ps2kb_pkg::CHAR_BITS-1:0]     rsp_key_char
);

   `PS2KB_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid && req_ready, "not idle after reset")
   `PS2KB_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_kind) && $stable(rsp_pointer_x) && $stable(rsp_pointer_y) && $stable(rsp_key_char), "stalled response changed")
   `PS2KB_ASSERT(a_key_fields, clock, reset, rsp_valid && rsp_event_kind == ps2kb_pkg::EVENT_KEY |-> rsp_key_char != '0 && rsp_pointer_x == '0 && rsp_pointer_y == '0 && !rsp_left_button && !rsp_right_button, "bad key event fields")
   `PS2KB_ASSERT(a_ptr_fields, clock, reset, rsp_valid && rsp_event_kind == ps2kb_pkg::EVENT_POINTER |-> rsp_key_char == '0, "bad pointer event fields")

endmodule

bind ps2_keyboard_mouse_byte_decoder_unit ps2kb_checker #(.COORD_BITS(COORD_BITS)) u_ps2kb_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_event_kind   (rsp.event_kind),
   .rsp_pointer_x    (rsp.pointer_x),
   .rsp_pointer_y    (rsp.pointer_y),
   .rsp_left_button  (rsp.left_button),
   .rsp_right_button (rsp.right_button),
   .rsp_key_char     (rsp.key_char)
);
